// ----- hdl/sdocts_pkg.sv -----
package sdocts_pkg;

    localparam int CFG_W      = 16;
    localparam int CS_W       = 3;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CS_W-1:0]   ABORT_SPECIFIER    = 3'd4;
    localparam logic [DATA_W-1:0] ABORT_CODE_TIMEOUT = 32'h0504_0000;
    localparam logic [DATA_W-1:0] ABORT_CODE_BAD_CS  = 32'h0504_0001;

    localparam logic [CFG_W-1:0] REQUEST_TIMEOUT_RESET  = 16'd100;
    localparam logic [CFG_W-1:0] READ_TIMEOUT_RESET     = 16'd50;
    localparam logic [CFG_W-1:0] RETRIEVE_TIMEOUT_RESET = 16'd100;

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_REQUEST = 2'd1,
        KIND_FRAME   = 2'd2,
        KIND_READ    = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REQUEST_TIMEOUT  = 2'd0,
        CFG_READ_TIMEOUT     = 2'd1,
        CFG_RETRIEVE_TIMEOUT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_WORK        = 3'd1,
        ST_NET_TIMEOUT = 3'd2,
        ST_SRV_ABORT   = 3'd3,
        ST_CS_ERR      = 3'd4,
        ST_WRITE_ERR   = 3'd5,
        ST_BUSY        = 3'd6,
        ST_IDLE_READ   = 3'd7
    } status_t;

    typedef enum logic {
        REASON_TIMEOUT = 1'b0,
        REASON_CS      = 1'b1
    } abort_reason_t;

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        kind_t             kind;
        logic [CS_W-1:0]   expected_cs;
        logic              tx_ready;
        logic [CS_W-1:0]   frame_cs;
        logic              frame_is_abort;
        logic [DATA_W-1:0] frame_data;
    } item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } queue_status_t;

endpackage

// ----- hdl/sdocts_front.sv -----
module sdocts_front (
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [2:0]                   s_expected_cs,
    input  logic                         s_tx_ready,
    input  logic [2:0]                   s_frame_cs,
    input  logic [31:0]                  s_frame_data,
    input  sdocts_pkg::queue_status_t    queue_status,
    output logic                         push,
    output sdocts_pkg::item_t            push_item
);
    import sdocts_pkg::*;

    assign s_ready = !queue_status.full;
    assign push    = s_valid && !queue_status.full;

    // The abort specifier is recognized here so the back only compares once.
    always_comb begin
        push_item.kind           = kind_t'(s_kind);
        push_item.expected_cs    = s_expected_cs;
        push_item.tx_ready       = s_tx_ready;
        push_item.frame_cs       = s_frame_cs;
        push_item.frame_is_abort = (s_frame_cs == ABORT_SPECIFIER);
        push_item.frame_data     = s_frame_data;
    end

endmodule

// ----- hdl/sdocts_queue.sv -----
module sdocts_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  sdocts_pkg::item_t         push_item,
    input  logic                      pop,
    output sdocts_pkg::item_t         pop_item,
    output sdocts_pkg::queue_status_t queue_status
);
    import sdocts_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && (count_reg != FULL_CNT);
    assign do_pop  = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item           = entry_reg[rd_ptr_reg];
    assign queue_status.full  = (count_reg == FULL_CNT);
    assign queue_status.valid = (count_reg != '0);

endmodule

// ----- hdl/sdocts_back.sv -----
module sdocts_back #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sdocts_pkg::queue_status_t queue_status,
    input  sdocts_pkg::item_t         pop_item,
    output logic                      pop,
    input  logic                      cfg_valid,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_status,
    output logic [31:0]               m_abort_code,
    output logic [31:0]               m_response_data,
    output logic                      m_send_request,
    output logic                      m_send_abort,
    output logic                      m_abort_reason
);
    import sdocts_pkg::*;

    localparam logic [32:0] TimerMax = (33'd1 << TIMER_WIDTH) - 33'd1;
    localparam logic [TIMER_WIDTH-1:0] TIMER_ONE = TIMER_WIDTH'(1);

    // A zero reload counts as one tick; wide reloads saturate to the counter.
    function automatic logic [TIMER_WIDTH-1:0] load_ticks(input logic [CFG_W-1:0] v);
        logic [32:0] wide;
        wide = 33'(v);
        if (v == '0) begin
            return TIMER_ONE;
        end
        if (wide > TimerMax) begin
            return TimerMax[TIMER_WIDTH-1:0];
        end
        return wide[TIMER_WIDTH-1:0];
    endfunction

    logic [TIMER_WIDTH-1:0] req_load_reg, read_load_reg, retr_load_reg;

    logic                   busy_reg, busy_next;
    status_t                status_reg, status_next;
    logic [TIMER_WIDTH-1:0] count_reg, count_next;
    logic [CS_W-1:0]        expected_reg, expected_next;
    logic [DATA_W-1:0]      abort_code_reg, abort_code_next;
    logic [DATA_W-1:0]      data_reg, data_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg, m_status_next;
    logic [DATA_W-1:0]      m_abort_code_reg, m_abort_code_next;
    logic [DATA_W-1:0]      m_data_reg, m_data_next;
    logic                   m_send_request_reg, m_send_request_next;
    logic                   m_send_abort_reg, m_send_abort_next;
    abort_reason_t          m_reason_reg, m_reason_next;

    logic exec;
    logic emit;

    // A word is carried out whenever the output register is free or drains now.
    assign exec = queue_status.valid && (!m_valid_reg || m_ready);
    assign pop  = exec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_load_reg  <= load_ticks(REQUEST_TIMEOUT_RESET);
            read_load_reg <= load_ticks(READ_TIMEOUT_RESET);
            retr_load_reg <= load_ticks(RETRIEVE_TIMEOUT_RESET);
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_REQUEST_TIMEOUT:  req_load_reg  <= load_ticks(cfg_data);
                CFG_READ_TIMEOUT:     read_load_reg <= load_ticks(cfg_data);
                CFG_RETRIEVE_TIMEOUT: retr_load_reg <= load_ticks(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        busy_next       = busy_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        expected_next   = expected_reg;
        abort_code_next = abort_code_reg;
        data_next       = data_reg;

        emit                = 1'b0;
        m_status_next       = m_status_reg;
        m_abort_code_next   = m_abort_code_reg;
        m_data_next         = m_data_reg;
        m_send_request_next = m_send_request_reg;
        m_send_abort_next   = m_send_abort_reg;
        m_reason_next       = m_reason_reg;

        if (exec) begin
            m_status_next       = ST_OK;
            m_abort_code_next   = '0;
            m_data_next         = '0;
            m_send_request_next = 1'b0;
            m_send_abort_next   = 1'b0;
            m_reason_next       = REASON_TIMEOUT;

            unique case (pop_item.kind)
                KIND_TICK: begin
                    if (busy_reg) begin
                        if (count_reg > TIMER_ONE) begin
                            count_next = count_reg - TIMER_ONE;
                        end else if (status_reg == ST_WORK) begin
                            status_next       = ST_NET_TIMEOUT;
                            count_next        = read_load_reg;
                            emit              = 1'b1;
                            m_status_next     = ST_NET_TIMEOUT;
                            m_send_abort_next = 1'b1;
                        end else begin
                            busy_next       = 1'b0;
                            status_next     = ST_OK;
                            abort_code_next = '0;
                            data_next       = '0;
                            count_next      = retr_load_reg;
                        end
                    end
                end
                KIND_REQUEST: begin
                    emit = 1'b1;
                    if (busy_reg) begin
                        m_status_next = ST_BUSY;
                    end else if (!pop_item.tx_ready) begin
                        status_next     = ST_OK;
                        abort_code_next = '0;
                        data_next       = '0;
                        count_next      = retr_load_reg;
                        m_status_next   = ST_WRITE_ERR;
                    end else begin
                        busy_next           = 1'b1;
                        status_next         = ST_WORK;
                        expected_next       = pop_item.expected_cs;
                        abort_code_next     = '0;
                        data_next           = '0;
                        count_next          = req_load_reg;
                        m_status_next       = ST_WORK;
                        m_send_request_next = 1'b1;
                    end
                end
                KIND_FRAME: begin
                    if (busy_reg && status_reg == ST_WORK) begin
                        count_next = read_load_reg;
                        if (pop_item.frame_is_abort) begin
                            abort_code_next = pop_item.frame_data;
                            status_next     = ST_SRV_ABORT;
                        end else if (pop_item.frame_cs == expected_reg) begin
                            data_next   = pop_item.frame_data;
                            status_next = ST_OK;
                        end else begin
                            status_next       = ST_CS_ERR;
                            emit              = 1'b1;
                            m_status_next     = ST_CS_ERR;
                            m_send_abort_next = 1'b1;
                            m_reason_next     = REASON_CS;
                        end
                    end
                end
                KIND_READ: begin
                    emit = 1'b1;
                    if (!busy_reg) begin
                        m_status_next = ST_IDLE_READ;
                    end else if (status_reg == ST_WORK) begin
                        m_status_next = ST_WORK;
                    end else begin
                        m_status_next     = status_reg;
                        m_abort_code_next = abort_code_reg;
                        m_data_next       = data_reg;
                        busy_next         = 1'b0;
                        status_next       = ST_OK;
                        abort_code_next   = '0;
                        data_next         = '0;
                        count_next        = retr_load_reg;
                    end
                end
                default: ;
            endcase
        end

        if (exec) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            status_reg     <= ST_OK;
            count_reg      <= load_ticks(RETRIEVE_TIMEOUT_RESET);
            expected_reg   <= '0;
            abort_code_reg <= '0;
            data_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            status_reg     <= status_next;
            count_reg      <= count_next;
            expected_reg   <= expected_next;
            abort_code_reg <= abort_code_next;
            data_reg       <= data_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg       <= m_status_next;
        m_abort_code_reg   <= m_abort_code_next;
        m_data_reg         <= m_data_next;
        m_send_request_reg <= m_send_request_next;
        m_send_abort_reg   <= m_send_abort_next;
        m_reason_reg       <= m_reason_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_abort_code    = m_abort_code_reg;
    assign m_response_data = m_data_reg;
    assign m_send_request  = m_send_request_reg;
    assign m_send_abort    = m_send_abort_reg;
    assign m_abort_reason  = m_reason_reg;

endmodule

// ----- hdl/sdo_client_transaction_supervisor.sv -----
// Supervises one outstanding CANopen SDO client transfer. Each input word is a
// tick, a request, a received SDO frame or a client read, and yields at most
// one result word (status, server abort code, reply data and send strobes).
// The block takes one word per clock while the queue has room: a classifying
// front pushes words into a two-entry queue and the back end retires one word
// per cycle unless a result waits on m_ready. A word is queued, then popped by
// the back end, which registers its result word in an output register. While
// a result waits on m_ready the queue takes in up to two more words before
// s_ready drops. Timeouts count ticks in a TIMER_WIDTH-bit counter; a zero
// reload counts as one tick and larger reloads saturate. Configuration (index
// 0 request timeout, 1 read timeout, 2 slot reload) must be written only while
// the block is idle; the block does not enforce it. cfg_ready is always high.
module sdo_client_transaction_supervisor #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [2:0]  s_expected_cs,
    input  logic        s_tx_ready,
    input  logic [2:0]  s_frame_cs,
    input  logic [31:0] s_frame_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_abort_code,
    output logic [31:0] m_response_data,
    output logic        m_send_request,
    output logic        m_send_abort,
    output logic        m_abort_reason,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sdocts_pkg::*;

    queue_status_t queue_status;
    item_t         push_item;
    item_t         pop_item;
    logic          push;
    logic          pop;

    assign cfg_ready = 1'b1;

    sdocts_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_expected_cs (s_expected_cs),
        .s_tx_ready    (s_tx_ready),
        .s_frame_cs    (s_frame_cs),
        .s_frame_data  (s_frame_data),
        .queue_status  (queue_status),
        .push          (push),
        .push_item     (push_item)
    );

    sdocts_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .push_item    (push_item),
        .pop          (pop),
        .pop_item     (pop_item),
        .queue_status (queue_status)
    );

    sdocts_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .queue_status    (queue_status),
        .pop_item        (pop_item),
        .pop             (pop),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_abort_code    (m_abort_code),
        .m_response_data (m_response_data),
        .m_send_request  (m_send_request),
        .m_send_abort    (m_send_abort),
        .m_abort_reason  (m_abort_reason)
    );

endmodule
